>>> hdl/pvrs_pkg.sv
// pvrs_pkg: shared constants, types and the gain table of the pcm volume ramp scaler
// used by every file under hdl; depends on nothing
`default_nettype none

package pvrs_pkg;

  // frame layout
  localparam int NFIELDS   = 4;
  localparam int LANES     = 4;
  localparam int SAMPLE_W  = 16;
  localparam int LANE_IDX_W = 3;

  // gain in q16, unity needs one bit above the fraction
  localparam int GAIN_W    = 17;
  localparam int UNITY     = 65536;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

  // ramp length and counter width
  localparam int RAMP_FRAMES = 256;
  localparam int RAMP_W      = $clog2(RAMP_FRAMES + 1);
  localparam int DIV_CNT_W   = $clog2(GAIN_W + 1);

  // configuration registers
  localparam int VOLUME_W   = 7;
  localparam int CHANNELS_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int VOLUME_MAX = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd2;

  // gain table, one entry per volume step
  localparam int ROM_DEPTH = VOLUME_MAX + 1;
  typedef logic [ROM_DEPTH-1:0][GAIN_W-1:0] gain_rom_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TARGET,
    ST_STEP,
    ST_DIV,
    ST_MULT,
    ST_MERGE
  } state_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [GAIN_W-1:0] mag;
    logic [RAMP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [GAIN_W:0]   quot;
  } div_rsp_t;

  // integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bit_v;
    rem   = n;
    root  = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + bit_v) begin
        rem  = rem - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root;
  endfunction

  // entry v is round(65536 * (v/100)^1.5) = round(sqrt(2^32 * v^3) / 1000)
  function automatic gain_rom_t build_gain_rom();
    gain_rom_t   rom;
    logic [63:0] cube;
    logic [63:0] s;
    for (int v = 0; v < ROM_DEPTH; v++) begin
      cube = 64'(v) * 64'(v) * 64'(v);
      s    = isqrt64(cube << 34);
      if (v == 0) begin
        rom[v] = '0;
      end else if (v >= VOLUME_MAX) begin
        rom[v] = GAIN_W'(UNITY);
      end else begin
        rom[v] = GAIN_W'((s + 64'd1000) / 64'd2000);
      end
    end
    return rom;
  endfunction

  localparam gain_rom_t GAIN_ROM = build_gain_rom();

  // volume above the table saturates at unity
  function automatic logic [GAIN_W-1:0] gain_lookup(input logic [VOLUME_W-1:0] vol);
    logic [GAIN_W-1:0] g;
    if (vol >= VOLUME_W'(VOLUME_MAX)) begin
      g = GAIN_W'(UNITY);
    end else begin
      g = GAIN_ROM[vol];
    end
    return g;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pvrs_in_if.sv
// pvrs_in_if: input frame channel, valid/ready with block flag and four samples
// depends on pvrs_pkg
`default_nettype none

interface pvrs_in_if import pvrs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       block_start;
  logic signed [SAMPLE_W-1:0] sample_0;
  logic signed [SAMPLE_W-1:0] sample_1;
  logic signed [SAMPLE_W-1:0] sample_2;
  logic signed [SAMPLE_W-1:0] sample_3;

  modport source (output valid, block_start, sample_0, sample_1, sample_2, sample_3,
                  input ready);
  modport sink (input valid, block_start, sample_0, sample_1, sample_2, sample_3,
                output ready);
endinterface

`default_nettype wire

>>> hdl/pvrs_out_if.sv
// pvrs_out_if: output frame channel, valid/ready with four scaled samples
// depends on pvrs_pkg
`default_nettype none

interface pvrs_out_if import pvrs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_0;
  logic signed [SAMPLE_W-1:0] out_1;
  logic signed [SAMPLE_W-1:0] out_2;
  logic signed [SAMPLE_W-1:0] out_3;

  modport source (output valid, out_0, out_1, out_2, out_3, input ready);
  modport sink (input valid, out_0, out_1, out_2, out_3, output ready);
endinterface

`default_nettype wire

>>> hdl/pvrs_cfg_if.sv
// pvrs_cfg_if: register write channel, valid/ready with register index and data
// depends on pvrs_pkg
`default_nettype none

interface pvrs_cfg_if import pvrs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/pcm_volume_ramp_scaler.sv
// pcm_volume_ramp_scaler: top level, control sequencer, lanes and output merge
// depends on pvrs_pkg, pvrs_in_if, pvrs_out_if, pvrs_cfg_if, pvrs_divider, pvrs_lane
//
// usage
//   frame_in carries one interleaved frame per transaction: block_start and four
//   signed 16-bit samples. frame_out returns one scaled frame per input frame, in
//   order. cfg (always ready) writes volume (index 0), muted (1), channels_in_use (2);
//   the user writes it only while the block is idle; the block does not enforce it.
// sequencing
//   one frame at a time. a frame passes the target, step, multiply and merge
//   states in order; while more than one ramp frame is left it also waits in the divide
//   state for the 17 iterations of the step divider, and with zero channels it goes
//   straight to merge. the four lanes multiply in parallel in the same cycle.
// reset
//   volume 100, unmuted, two channels, unity gain, no ramp in progress.
// stalls
//   the result sits in an output register until taken; the next frame is accepted
//   meanwhile and is held at the merge stage until the register frees up.
`default_nettype none

module pcm_volume_ramp_scaler import pvrs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  pvrs_in_if.sink    frame_in,
  pvrs_out_if.source frame_out,
  pvrs_cfg_if.sink   cfg
);

  state_t state;
  state_t state_next;

  logic [VOLUME_W-1:0]   volume;
  logic                  muted;
  logic [CHANNELS_W-1:0] channels;
  logic [GAIN_W-1:0]     current_gain;
  logic [GAIN_W-1:0]     ramp_target;
  logic [RAMP_W-1:0]     ramp_left;

  logic                       block_start;
  logic signed [SAMPLE_W-1:0] samples [NFIELDS];
  logic signed [SAMPLE_W-1:0] lane_out [NFIELDS];
  logic signed [SAMPLE_W-1:0] out_q [NFIELDS];
  logic                       out_valid;

  logic              in_fire;
  logic              cfg_fire;
  logic              out_fire;
  logic              in_ready;
  logic              div_start;
  logic              mult_load;
  logic              merge_fire;
  logic [GAIN_W-1:0] target_gain;
  logic signed [GAIN_W:0] diff;
  logic signed [GAIN_W:0] gain_sum;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // handshakes
  assign cfg.ready       = 1'b1;
  assign frame_in.ready  = in_ready;
  assign frame_out.valid = out_valid;
  assign in_fire  = frame_in.valid && in_ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign out_fire = out_valid && frame_out.ready;

  // target and step arithmetic
  always_comb begin
    target_gain = muted ? '0 : gain_lookup(volume);
    diff        = $signed({1'b0, ramp_target}) - $signed({1'b0, current_gain});
    gain_sum    = $signed({1'b0, current_gain}) + div_rsp.quot;
  end

  // divider request
  always_comb begin
    div_req.start   = div_start;
    div_req.neg     = diff[GAIN_W];
    div_req.mag     = diff[GAIN_W] ? GAIN_W'(-diff) : GAIN_W'(diff);
    div_req.divisor = ramp_left;
  end

  pvrs_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (channels == '0) ? ST_MERGE : ST_TARGET;
        end
      end
      ST_TARGET: state_next = ST_STEP;
      ST_STEP: begin
        state_next = (ramp_left > RAMP_W'(1)) ? ST_DIV : ST_MULT;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: state_next = ST_MERGE;
      ST_MERGE: begin
        if (merge_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = (state == ST_IDLE);
    div_start  = (state == ST_STEP) && (ramp_left > RAMP_W'(1));
    mult_load  = (state == ST_MULT);
    merge_fire = (state == ST_MERGE) && (!out_valid || frame_out.ready);
  end

  // control state, registers and ramp
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      volume       <= VOLUME_W'(VOLUME_MAX);
      muted        <= 1'b0;
      channels     <= CHANNELS_W'(2);
      current_gain <= GAIN_W'(UNITY);
      ramp_target  <= GAIN_W'(UNITY);
      ramp_left    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        unique case (cfg.index)
          CFG_VOLUME:   volume   <= cfg.data[VOLUME_W-1:0];
          CFG_MUTED:    muted    <= cfg.data[0];
          CFG_CHANNELS: channels <= cfg.data[CHANNELS_W-1:0];
          default: ;
        endcase
      end
      // a changed target on the first frame of a block restarts the ramp
      if (state == ST_TARGET && block_start && target_gain != ramp_target) begin
        ramp_target <= target_gain;
        ramp_left   <= RAMP_W'(RAMP_FRAMES);
      end
      // last ramp frame lands exactly on the target
      if (state == ST_STEP && ramp_left == RAMP_W'(1)) begin
        current_gain <= ramp_target;
        ramp_left    <= '0;
      end
      if (state == ST_DIV && div_rsp.done) begin
        current_gain <= gain_sum[GAIN_W-1:0];
        ramp_left    <= ramp_left - 1'b1;
      end
      if (merge_fire) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      block_start <= frame_in.block_start;
      samples[0]  <= frame_in.sample_0;
      samples[1]  <= frame_in.sample_1;
      samples[2]  <= frame_in.sample_2;
      samples[3]  <= frame_in.sample_3;
    end
  end

  // parallel lanes
  for (genvar l = 0; l < NFIELDS; l++) begin : g_lane
    if (l < LANES) begin : g_used
      pvrs_lane u_lane (
        .clk    (clk),
        .load   (mult_load),
        .sample (samples[l]),
        .gain   (current_gain),
        .result (lane_out[l])
      );
    end else begin : g_unused
      assign lane_out[l] = '0;
    end
  end

  // merge: inactive lanes give zero
  always_ff @(posedge clk) begin
    if (merge_fire) begin
      for (int l = 0; l < NFIELDS; l++) begin
        out_q[l] <= (LANE_IDX_W'(l) < channels) ? lane_out[l] : '0;
      end
    end
  end

  assign frame_out.out_0 = out_q[0];
  assign frame_out.out_1 = out_q[1];
  assign frame_out.out_2 = out_q[2];
  assign frame_out.out_3 = out_q[3];

  // checks
  a_ramp_bound: assert property (@(posedge clk) disable iff (rst)
    ramp_left <= RAMP_W'(RAMP_FRAMES))
    else $error("ramp counter above ramp length");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    current_gain <= GAIN_W'(UNITY))
    else $error("gain above unity");

  a_ramp_lands: assert property (@(posedge clk) disable iff (rst)
    ($past(ramp_left) == RAMP_W'(1) && ramp_left == '0) |-> current_gain == ramp_target)
    else $error("ramp did not land on target");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("divider result outside divide state");

endmodule

`default_nettype wire

>>> hdl/pvrs_divider.sv
// pvrs_divider: iterative restoring divider for the ramp step, one quotient bit a cycle
// signed result truncated toward zero; depends on pvrs_pkg
`default_nettype none

module pvrs_divider import pvrs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RAMP_W-1:0]    rem;
  logic [GAIN_W-1:0]    quo;
  logic [RAMP_W-1:0]    divisor;
  logic                 neg;
  logic [RAMP_W:0]      trial;
  logic                 fits;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[GAIN_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(GAIN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.mag;
      divisor <= req.divisor;
      neg     <= req.neg;
    end else if (busy) begin
      if (fits) begin
        rem <= RAMP_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[RAMP_W-1:0];
      end
      quo <= {quo[GAIN_W-2:0], fits};
    end
  end

  // apply the sign of the difference
  always_comb begin
    rsp.done = done;
    rsp.quot = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

endmodule

`default_nettype wire

>>> hdl/pvrs_lane.sv
// pvrs_lane: one channel lane, registered q16 product then round, shift and saturate
// depends on pvrs_pkg
`default_nettype none

module pvrs_lane import pvrs_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [GAIN_W-1:0]          gain,
  output logic signed [SAMPLE_W-1:0]      result
);

  logic signed [PROD_W-1:0] prod;
  logic                     neg;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        rounded;
  logic [PROD_W-17:0]       mag_q;

  // product register
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(sample * $signed({1'b0, gain}));
    end
  end

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    neg     = prod[PROD_W-1];
    mag     = neg ? PROD_W'(-prod) : PROD_W'(prod);
    rounded = mag + PROD_W'(UNITY / 2);
    mag_q   = rounded[PROD_W-1:16];
    if (!neg) begin
      if (mag_q > (PROD_W-16)'(32767)) begin
        result = 16'sh7fff;
      end else begin
        result = SAMPLE_W'(mag_q);
      end
    end else begin
      if (mag_q > (PROD_W-16)'(32768)) begin
        result = 16'sh8000;
      end else begin
        result = SAMPLE_W'(-$signed({1'b0, mag_q}));
      end
    end
  end

endmodule

`default_nettype wire
